/* sv/brfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package brfp_pkg;

  // Field widths of the streams and the capacity register
  localparam int CAP_W       = 11;
  localparam int DATA_W      = 8;
  localparam int OFF_W       = 10;
  localparam int PCT_W       = 7;
  localparam int POS_W       = 12;
  localparam int PROD_W      = 18;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // One operation handed to the storage core
  typedef struct packed {
    logic              go;
    op_t               op;
    logic [DATA_W-1:0] data;
    logic [OFF_W-1:0]  offset;
  } cmd_t;

  // Outcome of the last operation, valid the cycle after go
  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] data;
    logic [CAP_W-1:0]  used;
  } core_res_t;

endpackage

`default_nettype wire

/* sv/byte_ring_fifo_with_peek.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  tdata bits, lowest first
// in_       slave      opcode[1:0], data_in[9:2], offset[19:10], zero fill to 24
// out_      master     status[0], data_out[8:1], used_count[19:9],
//                      usage_percent[26:20], zero fill to 32
// cfg_      write      capacity_in_use[10:0], taken whenever cfg_wr_en is high
//
// The transfer on in_ updates the pointers and reads the byte. The ST_LATCH state
// then latches the outcome and loads count * 100 into the divider, 7
// compare-and-subtract steps follow, and the output register is loaded once out_
// is free. in_tready returns with out_tvalid, so a new transfer on in_ is taken
// only after the result of the last one has been loaded.
// in_tready is high only while no item is in work. A result waiting on out_
// does not block the next transfer; a later result waits until out_ is free.
// Reset (rst_n low at a clock edge) empties the FIFO and sets capacity to DEPTH, at most 1024.
module byte_ring_fifo_with_peek
  import brfp_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // opcode[1:0], data_in[9:2], offset[19:10]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // status[0], data_out[8:1], used_count[19:9], usage_percent[26:20]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CAP_W-1:0]       cfg_wr_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LATCH = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  cmd_t                   cmd;
  core_res_t              res;
  logic [CAP_W-1:0]       cap;
  logic                   div_start, div_done;
  logic [PCT_W-1:0]       pct;
  logic                   status_r;
  logic [DATA_W-1:0]      data_r;
  logic [CAP_W-1:0]       used_r;
  logic                   out_free, load;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign cmd.go     = in_tvalid && in_tready;
  assign cmd.op     = op_t'(in_tdata[1:0]);
  assign cmd.data   = in_tdata[9:2];
  assign cmd.offset = in_tdata[19:10];

  brfp_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd),
    .res        (res),
    .cap        (cap)
  );

  assign div_start = (state_r == ST_LATCH);

  brfp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .used (res.used),
    .cap  (cap),
    .done (div_done),
    .pct  (pct)
  );

  assign out_free = !out_tvalid_r || out_tready;

  // Sequencer: operate, latch, divide, hand over
  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE:  if (cmd.go) state_nxt = ST_LATCH;
      ST_LATCH: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (out_free) begin
            load      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Hold the operation outcome while the percentage is worked out
  always_ff @(posedge clk) begin
    if (state_r == ST_LATCH) begin
      status_r <= res.status;
      data_r   <= res.data;
      used_r   <= res.used;
    end
    if (load) begin
      out_tdata_r <= {
        (OUT_TDATA_W - PCT_W - CAP_W - DATA_W - 1)'(0), pct, used_r, data_r, status_r
      };
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef NO_ASSERTIONS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_accept_to_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == ST_LATCH)
    else $error("accepted item did not advance to latch");

  a_used_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LATCH |-> res.used <= cap)
    else $error("held byte count exceeds capacity");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[26:20] <= 7'd100)
    else $error("usage percentage above 100");
`endif

endmodule

`default_nettype wire

/* sv/brfp_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module brfp_core
  import brfp_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data,
  input  wire cmd_t             cmd,
  output core_res_t             res,
  output logic [CAP_W-1:0]      cap
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [CAP_W-1:0] CAP_RST = CAP_W'((DEPTH < 1024) ? DEPTH : 1024);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0]  cap_r, wp_r, rp_r;
  logic              wrap_r;
  logic [CAP_W-1:0]  wp_nxt, rp_nxt, wp_a, rp_a;
  logic              wrap_nxt, wr_a;
  logic              ok, mem_we, mem_re;
  logic [POS_W-1:0]  pos, raddr;
  logic [CAP_W-1:0]  cfg_cap;
  logic              status_r, hit_r;
  logic [DATA_W-1:0] rd_r;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [POS_W-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[ADDR_W-1:0];
  endfunction

  // Clamp a written capacity into 1..DEPTH
  always_comb begin
    cfg_cap = cfg_wr_data;
    if (cfg_cap == '0) cfg_cap = CAP_W'(1);
    if (32'(cfg_cap) > DEPTH) cfg_cap = CAP_W'(DEPTH);
  end

  // Decode the operation against the current pointers
  always_comb begin
    wp_a     = wp_r;
    rp_a     = rp_r;
    wr_a     = wrap_r;
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    wrap_nxt = wrap_r;
    ok       = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    pos      = POS_W'(rp_r) + POS_W'(cmd.offset);
    raddr    = POS_W'(rp_r);
    if (cmd.go) begin
      unique case (cmd.op)
        OP_PUSH: begin
          // wrap the write pointer first, even if the push then fails
          if (!wrap_r && wp_r == cap_r) begin
            wp_a = '0;
            wr_a = 1'b1;
          end
          ok       = wr_a ? (wp_a < rp_r) : (wp_a < cap_r);
          mem_we   = ok;
          wp_nxt   = ok ? wp_a + CAP_W'(1) : wp_a;
          wrap_nxt = wr_a;
        end
        OP_POP: begin
          // wrap the read pointer first, even if the pop then fails
          if (wrap_r && rp_r == cap_r) begin
            rp_a = '0;
            wr_a = 1'b0;
          end
          ok       = wr_a ? (rp_a < cap_r) : (rp_a < wp_r);
          mem_re   = ok;
          raddr    = POS_W'(rp_a);
          rp_nxt   = ok ? rp_a + CAP_W'(1) : rp_a;
          wrap_nxt = wr_a;
        end
        OP_PEEK: begin
          if (!wrap_r) begin
            ok = pos < POS_W'(wp_r);
          end else if (pos >= POS_W'(cap_r)) begin
            pos = pos - POS_W'(cap_r);
            ok  = pos < POS_W'(wp_r);
          end else begin
            ok = 1'b1;
          end
          mem_re = ok;
          raddr  = pos;
        end
        OP_CLEAR: begin
          ok       = 1'b1;
          wp_nxt   = '0;
          rp_nxt   = '0;
          wrap_nxt = 1'b0;
        end
      endcase
    end
  end

  // Pointer, flag and capacity registers; a capacity write empties the FIFO
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_RST;
      wp_r     <= '0;
      rp_r     <= '0;
      wrap_r   <= 1'b0;
      status_r <= 1'b0;
      hit_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      cap_r  <= cfg_cap;
      wp_r   <= '0;
      rp_r   <= '0;
      wrap_r <= 1'b0;
    end else if (cmd.go) begin
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      wrap_r   <= wrap_nxt;
      status_r <= !ok;
      hit_r    <= mem_re;
    end
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[to_addr(POS_W'(wp_a))] <= cmd.data;
    if (mem_re) rd_r <= mem[to_addr(raddr)];
  end

  // Held bytes from the updated pointers
  assign res.used   = wrap_r ? (cap_r - rp_r + wp_r) : (wp_r - rp_r);
  assign res.status = status_r;
  assign res.data   = hit_r ? rd_r : '0;
  assign cap        = cap_r;

endmodule

`default_nettype wire

/* sv/brfp_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module brfp_div
  import brfp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [CAP_W-1:0] used,
  input  wire logic [CAP_W-1:0] cap,
  output logic                  done,
  output logic [PCT_W-1:0]      pct
);

  localparam int CNT_W = $clog2(PCT_W);

  logic [PROD_W-1:0] rem_r, den_r;
  logic [PCT_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [PROD_W-1:0] used_w;

  assign used_w = PROD_W'(used);

  // Restoring division, one quotient bit a cycle, most significant first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(PCT_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  // Datapath: times 100 as shifted adds, then compare and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= (used_w << 6) + (used_w << 5) + (used_w << 2);
      den_r <= PROD_W'(cap) << (PCT_W - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      if (rem_r >= den_r) begin
        rem_r <= rem_r - den_r;
        quo_r <= {quo_r[PCT_W-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[PCT_W-2:0], 1'b0};
      end
      den_r <= den_r >> 1;
    end
  end

  assign done = done_r;
  assign pct  = quo_r;

endmodule

`default_nettype wire
